>>> sv/tfrx_pkg.sv
// Package: types, codes and constants shared by the text frame receiver.
`default_nettype none
package tfrx_pkg;

    typedef enum logic [2:0] {
        VERDICT_NONE     = 3'd0,
        VERDICT_ACCEPTED = 3'd1,
        VERDICT_TIMEOUT  = 3'd2,
        VERDICT_OVERFLOW = 3'd3,
        VERDICT_BAD_REQ  = 3'd4,
        VERDICT_BAD_SUM  = 3'd5
    } verdict_t;

    typedef enum logic [2:0] {
        REG_FIELD_SEP  = 3'd0,
        REG_SUM_MARK   = 3'd1,
        REG_END_MARK   = 3'd2,
        REG_TIMEOUT    = 3'd3,
        REG_HEX_LOWER  = 3'd4
    } reg_index_t;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic [1:0] field_index;
        verdict_t   verdict;
        logic [2:0] fields_seen;
        logic       had_checksum;
    } out_word_t;

    typedef struct packed {
        logic [7:0]  field_separator;
        logic [7:0]  checksum_marker;
        logic [7:0]  end_marker;
        logic [15:0] timeout_ticks;
        logic        hex_lower;
    } cfg_t;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned ELAPSED_W  = 17;

    localparam logic [7:0]  CR_BYTE          = 8'h0D;
    localparam logic [7:0]  RST_FIELD_SEP    = 8'd59;
    localparam logic [7:0]  RST_SUM_MARK     = 8'd42;
    localparam logic [7:0]  RST_END_MARK     = 8'd10;
    localparam logic [15:0] RST_TIMEOUT      = 16'd1000;
    localparam logic        RST_HEX_LOWER    = 1'b0;

    // ASCII hex digit for one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic lower);
        logic [7:0] base;
        base = lower ? 8'h61 : 8'h41;
        if (nib < 4'd10)
        begin
            hex_char = 8'h30 + {4'd0, nib};
        end
        else
        begin
            hex_char = base + {4'd0, nib} - 8'd10;
        end
    endfunction

endpackage
`default_nettype wire

>>> sv/tfrx_parser.sv
// Frame parser: frame state registers and the per-word update and result logic.
`default_nettype none
module tfrx_parser #(
    parameter int unsigned MAX_FRAME_LEN = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire tfrx_pkg::in_word_t item,
    input  wire tfrx_pkg::cfg_t     cfg,
    output logic                    res_valid,
    output tfrx_pkg::out_word_t     res
);

    localparam int unsigned POS_W = $clog2(MAX_FRAME_LEN + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_LEN);
    localparam logic [tfrx_pkg::ELAPSED_W-1:0] ELAPSED_SAT = '1;

    logic [POS_W-1:0]               pos_reg, pos_next;
    logic [1:0]                     field_reg, field_next;
    logic [7:0]                     xor_reg, xor_next;
    logic                           err_reg, err_next;
    logic                           in_sum_reg, in_sum_next;
    logic [7:0]                     first_reg, first_next;
    logic [7:0]                     second_reg, second_next;
    logic [1:0]                     cnt_reg, cnt_next;
    logic                           cmd_reg, cmd_next;
    logic [tfrx_pkg::ELAPSED_W-1:0] elapsed_reg, elapsed_next;

    logic       frame_open;
    logic       sum_ok;
    logic [7:0] ch;

    assign frame_open = (pos_reg != '0);
    assign ch         = item.rx_byte;
    assign sum_ok     = (cnt_reg == 2'd2)
                     && (first_reg == tfrx_pkg::hex_char(xor_reg[7:4], cfg.hex_lower))
                     && (second_reg == tfrx_pkg::hex_char(xor_reg[3:0], cfg.hex_lower));

    always_comb
    begin
        pos_next     = pos_reg;
        field_next   = field_reg;
        xor_next     = xor_reg;
        err_next     = err_reg;
        in_sum_next  = in_sum_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        cnt_next     = cnt_reg;
        cmd_next     = cmd_reg;
        elapsed_next = elapsed_reg;
        res_valid    = 1'b0;
        res          = '0;

        // verdict words carry the frame's field count and checksum flag
        res.fields_seen  = {1'b0, field_reg} + 3'd1;
        res.had_checksum = in_sum_reg;

        if (item.opcode == tfrx_pkg::OP_TICK)
        begin
            if (frame_open)
            begin
                if (elapsed_reg != ELAPSED_SAT)
                begin
                    elapsed_next = elapsed_reg + 1'b1;
                end
                if (elapsed_next > {1'b0, cfg.timeout_ticks})
                begin
                    res_valid   = 1'b1;
                    res.verdict = tfrx_pkg::VERDICT_TIMEOUT;
                    pos_next    = '0;
                end
            end
        end
        else if (ch == tfrx_pkg::CR_BYTE)
        begin
            // carriage returns are dropped
        end
        else if (ch == cfg.end_marker)
        begin
            if (frame_open)
            begin
                res_valid = 1'b1;
                pos_next  = '0;
                priority if (err_reg)
                begin
                    res.verdict = tfrx_pkg::VERDICT_OVERFLOW;
                end
                else if (field_reg == 2'd0 || !cmd_reg)
                begin
                    res.verdict = tfrx_pkg::VERDICT_BAD_REQ;
                end
                else if (in_sum_reg && !sum_ok)
                begin
                    res.verdict = tfrx_pkg::VERDICT_BAD_SUM;
                end
                else
                begin
                    res.verdict = tfrx_pkg::VERDICT_ACCEPTED;
                end
            end
        end
        else
        begin
            if (!frame_open)
            begin
                field_next   = '0;
                xor_next     = '0;
                err_next     = 1'b0;
                in_sum_next  = 1'b0;
                first_next   = '0;
                second_next  = '0;
                cnt_next     = '0;
                cmd_next     = 1'b0;
                elapsed_next = '0;
            end

            priority if (err_next)
            begin
                // drop until end of frame
            end
            else if (pos_reg >= POS_MAX)
            begin
                err_next = 1'b1;
            end
            else if (ch == cfg.field_separator)
            begin
                if (in_sum_next || field_next == 2'd3)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    field_next = field_next + 2'd1;
                    xor_next   = xor_next ^ ch;
                end
            end
            else if (ch == cfg.checksum_marker)
            begin
                if (in_sum_next)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    pos_next    = pos_reg + 1'b1;
                    in_sum_next = 1'b1;
                end
            end
            else if (in_sum_next)
            begin
                pos_next = pos_reg + 1'b1;
                if (cnt_next == 2'd0)
                begin
                    first_next = ch;
                end
                else if (cnt_next == 2'd1)
                begin
                    second_next = ch;
                end
                if (cnt_next != 2'd3)
                begin
                    cnt_next = cnt_next + 2'd1;
                end
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                xor_next = xor_next ^ ch;
                if (field_next == 2'd0)
                begin
                    cmd_next = 1'b1;
                end
                res_valid        = 1'b1;
                res.byte_valid   = 1'b1;
                res.out_byte     = ch;
                res.field_index  = field_next;
                res.fields_seen  = '0;
                res.had_checksum = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            field_reg   <= '0;
            xor_reg     <= '0;
            err_reg     <= 1'b0;
            in_sum_reg  <= 1'b0;
            first_reg   <= '0;
            second_reg  <= '0;
            cnt_reg     <= '0;
            cmd_reg     <= 1'b0;
            elapsed_reg <= '0;
        end
        else if (step)
        begin
            pos_reg     <= pos_next;
            field_reg   <= field_next;
            xor_reg     <= xor_next;
            err_reg     <= err_next;
            in_sum_reg  <= in_sum_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            cnt_reg     <= cnt_next;
            cmd_reg     <= cmd_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule
`default_nettype wire

>>> sv/text_frame_receiver_xor_check_top.sv
// Top level: config registers, frame parser and two-entry output buffer.
//
//  port group  | dir | handshake           | payload
//  ------------+-----+---------------------+----------------------------
//  in          | in  | in_valid/in_ready   | in_data  (opcode, rx_byte)
//  out         | out | out_valid/out_ready | out_data (result word)
//  cfg         | in  | cfg_we              | cfg_addr, cfg_wdata
//
// One word per cycle while in_ready is high: frame state updates in the cycle a word is accepted,
// and its result word (if any) is registered into head, or into skid while head still holds a word.
// The output buffer holds two words; in_ready drops only when both are full.
// Reset closes any open frame, empties the buffer and restores register defaults.
`default_nettype none
module text_frame_receiver_xor_check_top #(
    parameter int unsigned MAX_FRAME_LEN = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire tfrx_pkg::in_word_t                  in_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output tfrx_pkg::out_word_t                      out_data,
    input  wire logic                                cfg_we,
    input  wire logic [2:0]                          cfg_addr,
    input  wire logic [tfrx_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    tfrx_pkg::cfg_t      cfg_reg;
    tfrx_pkg::out_word_t res;
    tfrx_pkg::out_word_t head_reg, skid_reg;
    logic                head_valid_reg, skid_valid_reg;
    logic                res_valid;
    logic                step;
    logic                push;
    logic                pop;

    assign in_ready  = !skid_valid_reg;
    assign step      = in_valid && in_ready;
    assign push      = step && res_valid;
    assign pop       = head_valid_reg && out_ready;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.field_separator <= tfrx_pkg::RST_FIELD_SEP;
            cfg_reg.checksum_marker <= tfrx_pkg::RST_SUM_MARK;
            cfg_reg.end_marker      <= tfrx_pkg::RST_END_MARK;
            cfg_reg.timeout_ticks   <= tfrx_pkg::RST_TIMEOUT;
            cfg_reg.hex_lower       <= tfrx_pkg::RST_HEX_LOWER;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                tfrx_pkg::REG_FIELD_SEP: cfg_reg.field_separator <= cfg_wdata[7:0];
                tfrx_pkg::REG_SUM_MARK:  cfg_reg.checksum_marker <= cfg_wdata[7:0];
                tfrx_pkg::REG_END_MARK:  cfg_reg.end_marker      <= cfg_wdata[7:0];
                tfrx_pkg::REG_TIMEOUT:   cfg_reg.timeout_ticks   <= cfg_wdata;
                tfrx_pkg::REG_HEX_LOWER: cfg_reg.hex_lower       <= cfg_wdata[0];
                default:                 ;
            endcase
        end
    end

    tfrx_parser #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (in_data),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // skid only holds a word while head is also full
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= push;
            end
            else
            begin
                head_valid_reg <= push;
            end
        end
        else if (!head_valid_reg)
        begin
            head_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_reg <= skid_reg;
                skid_reg <= res;
            end
            else
            begin
                head_reg <= res;
            end
        end
        else if (!head_valid_reg)
        begin
            head_reg <= res;
        end
        else if (push)
        begin
            skid_reg <= res;
        end
    end

    a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid word held with empty head");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid_reg && !out_ready && push) |=> skid_valid_reg)
        else $error("word pushed during stall was not kept");

    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !skid_valid_reg && !push) |=> !out_valid)
        else $error("output still valid after last word drained");

endmodule
`default_nettype wire
